FILE: rtl/gsa_pkg.sv
`default_nettype none
package gsa_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int GEN_W = 16;

	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(64);

	// input command codes
	localparam logic [2:0] CMD_INIT    = 3'd0;
	localparam logic [2:0] CMD_ALLOC   = 3'd1;
	localparam logic [2:0] CMD_DESTROY = 3'd2;
	localparam logic [2:0] CMD_CHECK   = 3'd3;
	localparam logic [2:0] CMD_FLUSH   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_BAD_HANDLE = 2'd2,
		ST_NOT_INIT   = 2'd3
	} status_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_EMIT_PLAIN,
		OP_ALLOC_RD,
		OP_ALLOC_GEN,
		OP_ALLOC_EMIT,
		OP_HANDLE_RD,
		OP_HANDLE_EMIT,
		OP_FLUSH_START,
		OP_FLUSH_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t emit_st;   // status for OP_EMIT_PLAIN
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       ready_flag;
		logic       free_empty;
		logic       queue_empty;
		logic       flush_last;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/gsa_ctrl.sv
`default_nettype none
module gsa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire gsa_pkg::dp_stat_t stat,
	output gsa_pkg::ctl_cmd_t    ctl
);
	import gsa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_DISPATCH  = 6'b000010,
		S_ALLOC_RD  = 6'b000100,
		S_ALLOC_GEN = 6'b001000,
		S_HANDLE_RD = 6'b010000,
		S_FLUSH     = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctl.op      = OP_NONE;
		ctl.emit_st = ST_OK;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op    = OP_LOAD;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.cmd == CMD_INIT) begin
					if (stat.out_free) begin
						ctl.op    = OP_INIT;
						state_nxt = S_IDLE;
					end
				end else if (!(stat.cmd inside {CMD_ALLOC, CMD_DESTROY, CMD_CHECK,
						CMD_FLUSH})) begin
					// unused codes: dropped without a result
					state_nxt = S_IDLE;
				end else if (!stat.ready_flag) begin
					if (stat.out_free) begin
						ctl.op      = OP_EMIT_PLAIN;
						ctl.emit_st = ST_NOT_INIT;
						state_nxt   = S_IDLE;
					end
				end else if (stat.cmd == CMD_ALLOC) begin
					if (!stat.free_empty) begin
						ctl.op    = OP_ALLOC_RD;
						state_nxt = S_ALLOC_RD;
					end else if (stat.out_free) begin
						ctl.op      = OP_EMIT_PLAIN;
						ctl.emit_st = ST_NO_FREE;
						state_nxt   = S_IDLE;
					end
				end else if (stat.cmd == CMD_FLUSH) begin
					if (!stat.queue_empty) begin
						ctl.op    = OP_FLUSH_START;
						state_nxt = S_FLUSH;
					end else if (stat.out_free) begin
						ctl.op    = OP_EMIT_PLAIN;
						state_nxt = S_IDLE;
					end
				end else begin
					ctl.op    = OP_HANDLE_RD;
					state_nxt = S_HANDLE_RD;
				end
			end
			S_ALLOC_RD: begin
				ctl.op    = OP_ALLOC_GEN;
				state_nxt = S_ALLOC_GEN;
			end
			S_ALLOC_GEN: begin
				if (stat.out_free) begin
					ctl.op    = OP_ALLOC_EMIT;
					state_nxt = S_IDLE;
				end
			end
			S_HANDLE_RD: begin
				if (stat.out_free) begin
					ctl.op    = OP_HANDLE_EMIT;
					state_nxt = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					ctl.op = OP_FLUSH_STEP;
					if (stat.flush_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/gsa_dp.sv
`default_nettype none
module gsa_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gsa_pkg::ctl_cmd_t           ctl,
	output gsa_pkg::dp_stat_t                stat,
	input  wire logic                        cfg_we,
	input  wire logic [gsa_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire logic [2:0]                  cmd,
	input  wire logic [gsa_pkg::IDX_W-1:0]   slot_index,
	input  wire logic [gsa_pkg::GEN_W-1:0]   handle_generation,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [gsa_pkg::IDX_W-1:0]        out_index,
	output logic [gsa_pkg::GEN_W-1:0]        out_generation,
	output logic                             is_valid,
	output logic                             freed_any,
	output logic                             last
);
	import gsa_pkg::*;

	// item registers
	logic [2:0]       cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] hgen_q;

	// control state
	logic [CNT_W-1:0] slot_count_q;
	logic             ready_q;
	logic [CNT_W-1:0] active_q;
	logic [CNT_W-1:0] fc_q;
	logic [CNT_W-1:0] dc_q;
	logic [IDX_W-1:0] fptr_q;
	logic [SLOTS-1:0] in_use_q;
	logic [SLOTS-1:0] gen_vld_q;   // entry written since init, else reads zero
	logic [SLOTS-1:0] stk_wr_q;    // stack entry written since init, else holds its index
	logic             out_valid_q;

	// memories and their read registers
	logic [GEN_W-1:0] gen_mem [SLOTS];
	logic [IDX_W-1:0] stk_mem [SLOTS];
	logic [IDX_W-1:0] dq_mem  [SLOTS];
	logic [GEN_W-1:0] gen_rd_q;
	logic             gen_rd_vld_q;
	logic [IDX_W-1:0] stk_rd_q;
	logic             stk_rd_vld_q;
	logic [IDX_W-1:0] stk_addr_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] dq_rd_q;

	// output payload
	logic [1:0]       status_q;
	logic [IDX_W-1:0] oidx_q;
	logic [GEN_W-1:0] ogen_q;
	logic             ovld_q;
	logic             ofreed_q;
	logic             olast_q;

	logic [CNT_W-1:0] init_n;
	logic [IDX_W-1:0] pop_addr;
	logic [IDX_W-1:0] alloc_slot;
	logic [GEN_W-1:0] gen_eff;
	logic             live;
	logic             do_destroy;
	logic             push_ok;
	logic [CNT_W-1:0] fptr_inc;
	logic             flush_last;
	logic             emit;

	always_comb begin
		if (slot_count_q == '0) begin
			init_n = CNT_W'(1);
		end else if (slot_count_q > SLOTS_CNT) begin
			init_n = SLOTS_CNT;
		end else begin
			init_n = slot_count_q;
		end
	end

	assign pop_addr   = IDX_W'(fc_q - CNT_W'(1));
	assign alloc_slot = stk_rd_vld_q ? stk_rd_q : stk_addr_q;
	assign gen_eff    = gen_rd_vld_q ? gen_rd_q : '0;
	assign live       = ({1'b0, idx_q} < active_q) && (gen_eff == hgen_q) && in_use_q[idx_q];
	assign do_destroy = (ctl.op == OP_HANDLE_EMIT) && (cmd_q == CMD_DESTROY) && live
		&& (dc_q < SLOTS_CNT);
	assign push_ok    = fc_q < SLOTS_CNT;
	assign fptr_inc   = {1'b0, fptr_q} + CNT_W'(1);
	assign flush_last = fptr_inc == dc_q;
	assign emit       = (ctl.op == OP_INIT) || (ctl.op == OP_EMIT_PLAIN)
		|| (ctl.op == OP_ALLOC_EMIT) || (ctl.op == OP_HANDLE_EMIT)
		|| (ctl.op == OP_FLUSH_STEP);

	always_comb begin
		stat.cmd         = cmd_q;
		stat.ready_flag  = ready_q;
		stat.free_empty  = fc_q == '0;
		stat.queue_empty = dc_q == '0;
		stat.flush_last  = flush_last;
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			ready_q      <= 1'b0;
			active_q     <= '0;
			fc_q         <= '0;
			dc_q         <= '0;
			fptr_q       <= '0;
			in_use_q     <= '0;
			gen_vld_q    <= '0;
			stk_wr_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_INIT: begin
					ready_q   <= 1'b1;
					active_q  <= init_n;
					fc_q      <= init_n;
					dc_q      <= '0;
					in_use_q  <= '0;
					gen_vld_q <= '0;
					stk_wr_q  <= '0;
				end
				OP_ALLOC_RD: begin
					fc_q <= fc_q - CNT_W'(1);
				end
				OP_ALLOC_EMIT: begin
					in_use_q[slot_q] <= 1'b1;
				end
				OP_HANDLE_EMIT: begin
					if (do_destroy) begin
						in_use_q[idx_q]  <= 1'b0;
						gen_vld_q[idx_q] <= 1'b1;
						dc_q             <= dc_q + CNT_W'(1);
					end
				end
				OP_FLUSH_START: begin
					fptr_q <= '0;
				end
				OP_FLUSH_STEP: begin
					if (push_ok) begin
						stk_wr_q[fc_q[IDX_W-1:0]] <= 1'b1;
						fc_q                      <= fc_q + CNT_W'(1);
					end
					if (flush_last) begin
						dc_q <= '0;
					end else begin
						fptr_q <= fptr_inc[IDX_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item capture, read registers and output payload
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			cmd_q  <= cmd;
			idx_q  <= slot_index;
			hgen_q <= handle_generation;
		end
		if (ctl.op == OP_ALLOC_RD) begin
			stk_addr_q   <= pop_addr;
			stk_rd_vld_q <= stk_wr_q[pop_addr];
		end
		if (ctl.op == OP_ALLOC_GEN) begin
			slot_q       <= alloc_slot;
			gen_rd_vld_q <= gen_vld_q[alloc_slot];
		end
		if (ctl.op == OP_HANDLE_RD) begin
			gen_rd_vld_q <= gen_vld_q[idx_q];
		end
		if (emit) begin
			status_q <= ST_OK;
			oidx_q   <= '0;
			ogen_q   <= '0;
			ovld_q   <= 1'b0;
			ofreed_q <= 1'b0;
			olast_q  <= 1'b1;
			case (ctl.op)
				OP_EMIT_PLAIN: begin
					status_q <= ctl.emit_st;
				end
				OP_ALLOC_EMIT: begin
					oidx_q <= slot_q;
					ogen_q <= gen_eff;
				end
				OP_HANDLE_EMIT: begin
					if (cmd_q == CMD_CHECK) begin
						ovld_q <= live;
					end else if (!do_destroy) begin
						status_q <= ST_BAD_HANDLE;
					end
				end
				OP_FLUSH_STEP: begin
					oidx_q   <= dq_rd_q;
					ofreed_q <= 1'b1;
					olast_q  <= flush_last;
				end
				default: begin
				end
			endcase
		end
	end

	// generation table
	always_ff @(posedge clk) begin
		if (ctl.op == OP_ALLOC_GEN) begin
			gen_rd_q <= gen_mem[alloc_slot];
		end else if (ctl.op == OP_HANDLE_RD) begin
			gen_rd_q <= gen_mem[idx_q];
		end
		if (do_destroy) begin
			gen_mem[idx_q] <= gen_eff + GEN_W'(1);
		end
	end

	// free stack
	always_ff @(posedge clk) begin
		if (ctl.op == OP_ALLOC_RD) begin
			stk_rd_q <= stk_mem[pop_addr];
		end
		if ((ctl.op == OP_FLUSH_STEP) && push_ok) begin
			stk_mem[fc_q[IDX_W-1:0]] <= dq_rd_q;
		end
	end

	// destroy queue
	always_ff @(posedge clk) begin
		if (ctl.op == OP_FLUSH_START) begin
			dq_rd_q <= dq_mem[0];
		end else if ((ctl.op == OP_FLUSH_STEP) && !flush_last) begin
			dq_rd_q <= dq_mem[fptr_inc[IDX_W-1:0]];
		end
		if (do_destroy) begin
			dq_mem[dc_q[IDX_W-1:0]] <= idx_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_index      = oidx_q;
	assign out_generation = ogen_q;
	assign is_valid       = ovld_q;
	assign freed_any      = ofreed_q;
	assign last           = olast_q;

endmodule
`default_nettype wire

FILE: rtl/generational_slot_allocator.sv
// Slot allocator with generation-tagged handles.
// Input channel (in_valid/in_ready) carries cmd, slot_index, handle_generation;
// output channel (out_valid/out_ready) carries one or more result items.
// cmd: init loads slots 0..n-1 onto a LIFO free stack (n is slot_count, 0 taken
// as 1, above 64 as 64), allocate pops one (highest index first), destroy
// retires a live handle into the destroy queue and bumps its generation, check
// tests a handle, flush returns every queued slot to the free stack with one
// result per slot, last on the final one. slot_count is to be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// One item at a time: init, not-initialized, no-free-slot and empty-flush
// results come from the dispatch step, check and destroy after the generation
// table read, allocate after the stack read and then the generation table read;
// flush writes one result per queued slot. in_ready is high again once the last
// result is written; a result waiting in the output register delays the next.
// The output register lets the next item be accepted while a result waits;
// while the receiver stalls, the block holds at the next result it must emit.
// Reset: not initialized (every command but init reports status 3), slot_count
// 64, all generations zero. No clearing pass: per-entry valid bits stand in for
// the cleared tables and are cleared at once by reset and by init.
`default_nettype none
module generational_slot_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [gsa_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [2:0]                cmd,
	input  wire logic [gsa_pkg::IDX_W-1:0] slot_index,
	input  wire logic [gsa_pkg::GEN_W-1:0] handle_generation,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic [gsa_pkg::IDX_W-1:0]      out_index,
	output logic [gsa_pkg::GEN_W-1:0]      out_generation,
	output logic                           is_valid,
	output logic                           freed_any,
	output logic                           last
);
	import gsa_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// sequencer: decodes the item and steps the table accesses
	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// tables, stacks, counters and the output register
	gsa_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.cmd               (cmd),
		.slot_index        (slot_index),
		.handle_generation (handle_generation),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.is_valid          (is_valid),
		.freed_any         (freed_any),
		.last              (last)
	);

	// busy after every accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// a result is only produced into a free output register
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_INIT || ctl.op == OP_EMIT_PLAIN || ctl.op == OP_ALLOC_EMIT
		|| ctl.op == OP_HANDLE_EMIT || ctl.op == OP_FLUSH_STEP)
		|-> (!out_valid || out_ready))
		else $error("result overwrote a pending result");

	// an error result always ends its item
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && !freed_any)
		else $error("error result not final");

endmodule
`default_nettype wire

FILE: tb/tb_generational_slot_allocator.sv
`default_nettype none
module tb_generational_slot_allocator;
	import gsa_pkg::*;

	// Command codes above flush are ignored by the block and give no result
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	// Idle-time draws, one stream per side
	localparam int SENDER   = 0;
	localparam int RECEIVER = 1;

	// Flush drains up to SLOTS results, each after a short step; allow margin
	localparam int SETTLE_CYCLES   = 100;
	// Receiver hold-off long enough to fill the block and stall the input
	localparam int HOLD_OFF_CYCLES = 400;
	// Cycles without an accepted input or a final result before the run is
	// declared hung; a full flush under the longest receiver gaps stays far below
	localparam int QUIET_LIMIT     = 6000;

	// One result item as seen on the output channel
	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic             valid;
		logic             freed;
		logic             last;
	} slot_result_t;

	// Mirror of the slot map: tracks generations, in-use bits, free stack and
	// retire queue, and keeps the results each accepted command should produce.
	class slot_map_scoreboard;
		logic [GEN_W-1:0] gen_tbl[SLOTS];
		bit               live[SLOTS];
		logic [IDX_W-1:0] free_stack[SLOTS];
		int               free_depth;
		logic [IDX_W-1:0] retired[SLOTS];
		int               retired_depth;
		bit               loaded;
		int               slot_count;
		int               active;
		slot_result_t     awaited[$];
		int               errors;

		function new();
			foreach (gen_tbl[i]) begin
				gen_tbl[i] = '0;
				live[i] = 1'b0;
			end
			free_depth = 0;
			retired_depth = 0;
			loaded = 1'b0;
			slot_count = SLOT_COUNT_RST;
			active = 0;
			errors = 0;
		endfunction

		function void set_slot_count(logic [CNT_W-1:0] v);
			slot_count = v;
		endfunction

		function bit is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
			return idx < active && gen_tbl[idx] == g && live[idx];
		endfunction

		// Random in-range slot whose in-use bit equals want_live; -1 if none
		function int pick_slot(bit want_live);
			int hits[$];
			for (int i = 0; i < active; i++)
				if (live[i] == want_live)
					hits = {hits, i};
			if (hits.size() == 0)
				return -1;
			return hits[$urandom_range(0, hits.size() - 1)];
		endfunction

		function void add(status_t st, int idx, int g, bit v, bit f, bit l);
			slot_result_t r;
			r.status = st;
			r.index = IDX_W'(idx);
			r.generation = GEN_W'(g);
			r.valid = v;
			r.freed = f;
			r.last = l;
			awaited = {awaited, r};
		endfunction

		function void note_command(logic [2:0] c, logic [IDX_W-1:0] idx,
				logic [GEN_W-1:0] g);
			int n;
			logic [IDX_W-1:0] s;
			if (c > CMD_FLUSH)
				return;
			if (c == CMD_INIT) begin
				// count 0 is taken as one slot, anything above SLOTS as SLOTS
				n = slot_count < 1 ? 1 : (slot_count > SLOTS ? SLOTS : slot_count);
				foreach (gen_tbl[i]) begin
					gen_tbl[i] = '0;
					live[i] = 1'b0;
				end
				for (int i = 0; i < n; i++)
					free_stack[i] = IDX_W'(i);
				free_depth = n;
				retired_depth = 0;
				active = n;
				loaded = 1'b1;
				add(ST_OK, 0, 0, 0, 0, 1);
				return;
			end
			if (!loaded) begin
				add(ST_NOT_INIT, 0, 0, 0, 0, 1);
				return;
			end
			case (c)
				CMD_ALLOC: begin
					if (free_depth == 0) begin
						add(ST_NO_FREE, 0, 0, 0, 0, 1);
					end else begin
						free_depth--;
						s = free_stack[free_depth];
						live[s] = 1'b1;
						add(ST_OK, s, gen_tbl[s], 0, 0, 1);
					end
				end
				CMD_DESTROY: begin
					if (!is_live(idx, g) || retired_depth >= SLOTS) begin
						add(ST_BAD_HANDLE, 0, 0, 0, 0, 1);
					end else begin
						gen_tbl[idx] = gen_tbl[idx] + 1'b1;
						live[idx] = 1'b0;
						retired[retired_depth] = idx;
						retired_depth++;
						add(ST_OK, 0, 0, 0, 0, 1);
					end
				end
				CMD_CHECK: begin
					add(ST_OK, 0, 0, is_live(idx, g), 0, 1);
				end
				default: begin
					// flush: queue order back onto the free stack, one result per slot
					if (retired_depth == 0) begin
						add(ST_OK, 0, 0, 0, 0, 1);
					end else begin
						for (int i = 0; i < retired_depth; i++) begin
							if (free_depth < SLOTS) begin
								free_stack[free_depth] = retired[i];
								free_depth++;
							end
							add(ST_OK, retired[i], 0, 0, 1, i == retired_depth - 1);
						end
						retired_depth = 0;
					end
				end
			endcase
		endfunction

		function void flag(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
		endfunction

		function void check_result(slot_result_t got);
			slot_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status %0d index %0d", $time,
					got.status, got.index);
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.index !== want.index)
				flag("out_index", want.index, got.index);
			if (got.generation !== want.generation)
				flag("out_generation", want.generation, got.generation);
			if (got.valid !== want.valid)
				flag("is_valid", want.valid, got.valid);
			if (got.freed !== want.freed)
				flag("freed_any", want.freed, got.freed);
			if (got.last !== want.last)
				flag("last", want.last, got.last);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [2:0]       cmd = CMD_INIT;
	logic [IDX_W-1:0] slot_index = '0;
	logic [GEN_W-1:0] handle_generation = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       status;
	logic [IDX_W-1:0] out_index;
	logic [GEN_W-1:0] out_generation;
	logic             is_valid;
	logic             freed_any;
	logic             last;

	slot_map_scoreboard book;
	int                 calm_left[2];
	bit                 hold_off_request = 1'b0;
	int                 quiet_cycles = 0;

	generational_slot_allocator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cmd               (cmd),
		.slot_index        (slot_index),
		.handle_generation (handle_generation),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.is_valid          (is_valid),
		.freed_any         (freed_any),
		.last              (last)
	);

	always #5 clk = ~clk;

	// Idle cycles before the next item on one side, drawn at random, with
	// occasional calm stretches where that side never idles.
	function automatic int draw_gap(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			calm_left[side] = $urandom_range(5, 25);
		return $urandom_range(0, 17);
	endfunction

	// Present one command item and hold it until accepted. Valid is only
	// lowered when a gap follows, so back-to-back items keep it high.
	task automatic offer(input logic [2:0] c, input logic [IDX_W-1:0] idx,
			input logic [GEN_W-1:0] g);
		int gap;
		gap = draw_gap(SENDER);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		slot_index <= idx;
		handle_generation <= g;
		do @(posedge clk); while (in_ready !== 1'b1);
		book.note_command(c, idx, g);
	endtask

	// Drop valid, wait for all outstanding results, then let a flush or an
	// ignored command finish inside the block before anything else happens.
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		book.set_slot_count(v);
	endtask

	// Mostly well-formed traffic built from live handles in the mirror, plus
	// stale handles, random noise and ignored codes.
	task automatic run_random_phase(input int n_items);
		int               sent;
		int               roll;
		int               pick;
		logic [2:0]       c;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] g;
		offer(CMD_INIT, IDX_W'($urandom), GEN_W'($urandom));
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(0, 99);
			idx = IDX_W'($urandom);
			g = GEN_W'($urandom);
			c = CMD_ALLOC;
			if (roll < 30) begin
				c = CMD_ALLOC;
			end else if (roll < 55) begin
				pick = book.pick_slot(1'b1);
				if (pick >= 0) begin
					c = CMD_DESTROY;
					idx = IDX_W'(pick);
					g = book.gen_tbl[pick];
				end
			end else if (roll < 65) begin
				c = CMD_CHECK;
				pick = book.pick_slot(1'b1);
				if (pick >= 0) begin
					idx = IDX_W'(pick);
					g = book.gen_tbl[pick];
				end
			end else if (roll < 72) begin
				// live slot, one generation bit off
				c = CMD_CHECK;
				pick = book.pick_slot(1'b1);
				if (pick >= 0) begin
					idx = IDX_W'(pick);
					g = book.gen_tbl[pick] ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
				end
			end else if (roll < 78) begin
				// double free: slot not in use, current generation
				c = CMD_DESTROY;
				pick = book.pick_slot(1'b0);
				if (pick >= 0) begin
					idx = IDX_W'(pick);
					g = book.gen_tbl[pick];
				end
			end else if (roll < 88) begin
				c = CMD_FLUSH;
			end else if (roll < 90) begin
				c = CMD_INIT;
			end else if (roll < 96) begin
				c = $urandom_range(0, 1) ? CMD_DESTROY : CMD_CHECK;
			end else begin
				c = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			end
			offer(c, idx, g);
			if (c <= CMD_FLUSH)
				sent++;
		end
		settle();
	endtask

	// Watchdog: an accepted input or an accepted final result counts as progress
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1)
				|| (out_valid === 1'b1 && out_ready && last === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: random ready gaps, one long hold-off on request
	initial begin : result_sink
		int           gap;
		slot_result_t got;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(RECEIVER);
			if (hold_off_request) begin
				gap = HOLD_OFF_CYCLES;
				hold_off_request = 1'b0;
			end
			if (gap > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.status = status_t'(status);
			got.index = out_index;
			got.generation = out_generation;
			got.valid = is_valid;
			got.freed = freed_any;
			got.last = last;
			book.check_result(got);
		end
	end

	initial begin : stimulus
		int pick;
		book = new();
		calm_left[SENDER] = 0;
		calm_left[RECEIVER] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Before init: every command reports not initialized; spare code ignored
		offer(CMD_ALLOC, '0, '0);
		offer(CMD_DESTROY, '1, '1);
		offer(CMD_CHECK, '0, '1);
		offer(CMD_FLUSH, '1, '0);
		offer(CMD_SPARE_LAST, '1, '1);
		// Reset slot count: highest slot comes out first, generation zero
		offer(CMD_INIT, '0, '0);
		offer(CMD_ALLOC, '0, '0);
		offer(CMD_CHECK, IDX_W'(SLOTS - 1), '0);
		offer(CMD_CHECK, IDX_W'(SLOTS - 1), '1);
		offer(CMD_DESTROY, IDX_W'(SLOTS - 1), '1);
		offer(CMD_DESTROY, IDX_W'(SLOTS - 1), '0);
		// same slot again with its bumped generation: not in use, rejected
		offer(CMD_DESTROY, IDX_W'(SLOTS - 1), GEN_W'(1));
		offer(CMD_CHECK, IDX_W'(SLOTS - 1), GEN_W'(1));
		offer(CMD_FLUSH, '0, '0);
		offer(CMD_FLUSH, '0, '0);  // empty queue
		offer(CMD_ALLOC, '0, '0);  // reuse carries generation 1
		offer(CMD_SPARE_FIRST, '1, '1);
		settle();

		// Slot count 0 acts as a single slot
		write_slot_count('0);
		offer(CMD_INIT, '1, '1);
		offer(CMD_ALLOC, '0, '0);
		offer(CMD_ALLOC, '0, '0);  // stack empty
		offer(CMD_CHECK, '1, '0);  // index past the loaded count
		offer(CMD_DESTROY, IDX_W'(1), '0);
		offer(CMD_INIT, '0, '0);   // re-init clears the in-use bits
		offer(CMD_CHECK, '0, '0);
		settle();

		// Count above SLOTS clamps to the full table. Fill, drain in random
		// order and flush everything at once, with the receiver held off so
		// the block backs up onto its input.
		write_slot_count('1);
		hold_off_request = 1'b1;
		offer(CMD_INIT, '0, '0);
		repeat (SLOTS + 1) offer(CMD_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
		pick = book.pick_slot(1'b1);
		while (pick >= 0) begin
			offer(CMD_DESTROY, IDX_W'(pick), book.gen_tbl[pick]);
			pick = book.pick_slot(1'b1);
		end
		offer(CMD_FLUSH, '0, '0);
		settle();

		write_slot_count(CNT_W'(1));
		run_random_phase(17);
		write_slot_count(SLOTS_CNT);
		run_random_phase(17);
		write_slot_count(CNT_W'($urandom_range(2, SLOTS - 1)));
		run_random_phase(17);
		write_slot_count(CNT_W'($urandom_range(SLOTS + 1, 126)));
		run_random_phase(17);

		if (book.errors == 0 && book.awaited.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/gsa_pkg.sv
rtl/gsa_ctrl.sv
rtl/gsa_dp.sv
rtl/generational_slot_allocator.sv
tb/tb_generational_slot_allocator.sv
